### hw/rtl/lldwa_pkg.sv
// ----------------------------------------------------------------------------
// lldwa_pkg
// Shared types and constants for the least-loaded dispatcher with source
// affinity: register indexes, function codes, FSM states, control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lldwa_pkg;

  localparam int DEF_NUM_WORKERS = 8;
  localparam int DEF_NUM_SOURCES = 64;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int SRC_ID_W    = 6;
  localparam int WORKER_ID_W = 3;
  localparam int WIU_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_AFFINITY_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKERS_IN_USE  = 1'b1;

  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic             AFFINITY_RESET = 1'b1;
  localparam logic [WIU_W-1:0] WIU_RESET      = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_END,
    ST_REREAD,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic clear;
    logic take;
    logic decide;
    logic scan;
    logic reread;
    logic update;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fast_path;
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/lldwa_ctrl.sv
// ----------------------------------------------------------------------------
// lldwa_ctrl
// Sequencer: memory clear after reset, source lookup, load scan, counter
// update and hand-off of the result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lldwa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  lldwa_pkg::dp_status_t  status_i,
  output lldwa_pkg::dp_cmd_t     cmd_o
);
  import lldwa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE:   state_d = status_i.fast_path ? ST_UPDATE : ST_SCAN;
      ST_SCAN:     if (status_i.scan_last) state_d = ST_SCAN_END;
      ST_SCAN_END: state_d = ST_REREAD;
      ST_REREAD:   state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_RESULT;
      ST_RESULT:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_SCAN:   cmd_o.scan = 1'b1;
      ST_REREAD: cmd_o.reread = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_RESULT: cmd_o.emit = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/lldwa_dp.sv
// ----------------------------------------------------------------------------
// lldwa_dp
// Datapath: config registers, source record memory, worker load memory,
// running minimum of the load scan and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lldwa_dp #(
  parameter int NUM_WORKERS = lldwa_pkg::DEF_NUM_WORKERS,
  parameter int NUM_SOURCES = lldwa_pkg::DEF_NUM_SOURCES,
  parameter int COUNT_WIDTH = lldwa_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lldwa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lldwa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_func_i,
  input  logic [lldwa_pkg::SRC_ID_W-1:0]      in_source_id_i,
  input  logic [lldwa_pkg::WORKER_ID_W-1:0]   in_finishing_worker_i,
  input  lldwa_pkg::dp_cmd_t                  cmd_i,
  output lldwa_pkg::dp_status_t               status_o,
  output logic [lldwa_pkg::WORKER_ID_W-1:0]   out_chosen_worker_o,
  output logic                                out_dispatched_o,
  output logic                                out_finish_done_o
);
  import lldwa_pkg::*;

  localparam int WIW  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int WW   = (WIW > WORKER_ID_W) ? WIW : WORKER_ID_W;
  localparam int NCW  = $clog2(NUM_WORKERS + 1);
  localparam int SIW  = $clog2(NUM_SOURCES);
  localparam int CLRN = (NUM_SOURCES > NUM_WORKERS) ? NUM_SOURCES : NUM_WORKERS;
  localparam int CLRW = $clog2(CLRN);
  localparam int RECW = 1 + COUNT_WIDTH + WORKER_ID_W;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  // config
  logic             aff_en_q;
  logic [WIU_W-1:0] wiu_q;
  logic [NCW-1:0]   n_eff;

  // item
  logic                   func_q;
  logic [SRC_ID_W-1:0]    src_q;
  logic [WORKER_ID_W-1:0] fw_q;
  logic [WW-1:0]          w_q, w_d;
  logic                   new_rec_q;

  // memories; record = {active, pending, worker}
  logic [RECW-1:0]        src_mem [NUM_SOURCES];
  logic [COUNT_WIDTH-1:0] ld_mem  [NUM_WORKERS];
  logic [RECW-1:0]        src_rd_q;
  logic [COUNT_WIDTH-1:0] ld_rd_q;

  logic                   src_we;
  logic [SIW-1:0]         src_waddr;
  logic [RECW-1:0]        src_wdata;
  logic                   ld_re, ld_we;
  logic [WIW-1:0]         ld_raddr, ld_waddr;
  logic [COUNT_WIDTH-1:0] ld_wdata;

  // scan
  logic [NCW-1:0]         scan_q;
  logic                   cmp_v_q;
  logic [WIW-1:0]         cmp_idx_q;
  logic [COUNT_WIDTH-1:0] best_val_q;
  logic [WIW-1:0]         best_idx_q;
  logic [CLRW-1:0]        clr_q;

  logic                   src_ok, src_hit, fast;
  logic                   rec_act;
  logic [COUNT_WIDTH-1:0] rec_pend;
  logic [WORKER_ID_W-1:0] rec_wkr;
  logic [SIW-1:0]         src_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aff_en_q <= AFFINITY_RESET;
      wiu_q    <= WIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AFFINITY_ENABLE: aff_en_q <= cfg_data_i[0];
        REG_WORKERS_IN_USE:  wiu_q    <= cfg_data_i[WIU_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the worker count is clipped
  always_comb begin
    if (wiu_q == '0) begin
      n_eff = NCW'(1);
    end else if (32'(wiu_q) > 32'(NUM_WORKERS)) begin
      n_eff = NCW'(NUM_WORKERS);
    end else begin
      n_eff = NCW'(wiu_q);
    end
  end

  assign src_ok   = 32'(src_q) < 32'(NUM_SOURCES);
  assign src_addr = SIW'(src_q);
  assign rec_act  = src_rd_q[RECW-1];
  assign rec_pend = src_rd_q[RECW-2 -: COUNT_WIDTH];
  assign rec_wkr  = src_rd_q[WORKER_ID_W-1:0];
  assign src_hit  = src_ok && rec_act;
  assign fast     = (func_q == FUNC_FINISH) || (src_hit && aff_en_q);

  always_comb begin
    src_we    = 1'b0;
    src_waddr = src_addr;
    src_wdata = '0;
    ld_re     = 1'b0;
    ld_raddr  = '0;
    ld_we     = 1'b0;
    ld_waddr  = w_q[WIW-1:0];
    ld_wdata  = '0;
    w_d       = w_q;
    if (cmd_i.clear) begin
      src_we    = 32'(clr_q) < 32'(NUM_SOURCES);
      src_waddr = clr_q[SIW-1:0];
      ld_we     = 32'(clr_q) < 32'(NUM_WORKERS);
      ld_waddr  = clr_q[WIW-1:0];
    end
    if (cmd_i.decide) begin
      if (func_q == FUNC_FINISH) begin
        w_d = WW'(fw_q);
        if (src_hit) begin
          src_we = 1'b1;
          if (rec_pend <= CNT_ONE) begin
            src_wdata = {1'b0, CNT_ZERO, rec_wkr};
          end else begin
            src_wdata = {1'b1, rec_pend - CNT_ONE, rec_wkr};
          end
        end
      end else if (src_hit && aff_en_q) begin
        w_d       = WW'(rec_wkr);
        src_we    = 1'b1;
        src_wdata = {1'b1, sat_inc(rec_pend), rec_wkr};
      end
      ld_re    = 1'b1;
      ld_raddr = w_d[WIW-1:0];
    end
    if (cmd_i.scan) begin
      ld_re    = 1'b1;
      ld_raddr = scan_q[WIW-1:0];
    end
    if (cmd_i.reread) begin
      w_d      = WW'(best_idx_q);
      ld_re    = 1'b1;
      ld_raddr = best_idx_q;
    end
    if (cmd_i.update) begin
      ld_we = 32'(w_q) < 32'(NUM_WORKERS);
      if (func_q == FUNC_SUBMIT) begin
        ld_wdata = sat_inc(ld_rd_q);
      end else begin
        ld_wdata = (ld_rd_q != CNT_ZERO) ? ld_rd_q - CNT_ONE : ld_rd_q;
      end
      src_we    = new_rec_q;
      src_wdata = {1'b1, CNT_ONE, w_q[WORKER_ID_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    if (cmd_i.take) begin
      src_rd_q <= src_mem[SIW'(in_source_id_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      ld_mem[ld_waddr] <= ld_wdata;
    end
    if (ld_re) begin
      ld_rd_q <= ld_mem[ld_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      scan_q    <= '0;
      cmp_v_q   <= 1'b0;
      new_rec_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + CLRW'(1);
      end
      if (cmd_i.take) begin
        scan_q <= '0;
      end else if (cmd_i.scan) begin
        scan_q <= scan_q + NCW'(1);
      end
      cmp_v_q <= cmd_i.scan;
      if (cmd_i.decide) begin
        new_rec_q <= (func_q == FUNC_SUBMIT) && !fast && src_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q <= in_func_i;
      src_q  <= in_source_id_i;
      fw_q   <= in_finishing_worker_i;
    end
    w_q       <= w_d;
    cmp_idx_q <= scan_q[WIW-1:0];
    // strict compare keeps the lowest index on ties
    if (cmp_v_q && ((cmp_idx_q == '0) || (ld_rd_q < best_val_q))) begin
      best_val_q <= ld_rd_q;
      best_idx_q <= cmp_idx_q;
    end
    if (cmd_i.emit) begin
      out_chosen_worker_o <= w_q[WORKER_ID_W-1:0];
      out_dispatched_o    <= func_q == FUNC_SUBMIT;
      out_finish_done_o   <= func_q == FUNC_FINISH;
    end
  end

  assign status_o.clr_last  = clr_q == CLRW'(CLRN - 1);
  assign status_o.fast_path = fast;
  assign status_o.scan_last = scan_q == (n_eff - NCW'(1));

endmodule

`default_nettype wire

### hw/rtl/least_loaded_dispatch_with_affinity_unit.sv
// Flow: one item at a time; a finish or an affinity hit skips the load scan and goes
//   from the source lookup to the counter update, while a least-loaded pick first
//   scans n worker loads (n = effective workers in use), reading one worker load per
//   cycle from the load memory, which has a single read port.
// Reset: asynchronous, active low; a clear pass over max(NUM_SOURCES, NUM_WORKERS)
//   entries (64 by default) runs after reset before the first item is taken.
// ----------------------------------------------------------------------------
// least_loaded_dispatch_with_affinity_unit
// Task dispatcher: sends a submit to its source's recorded worker or to the
// least-loaded worker, and tracks per-worker and per-source pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_dispatch_with_affinity_unit #(
  parameter int NUM_WORKERS = lldwa_pkg::DEF_NUM_WORKERS,
  parameter int NUM_SOURCES = lldwa_pkg::DEF_NUM_SOURCES,
  parameter int COUNT_WIDTH = lldwa_pkg::DEF_COUNT_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lldwa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lldwa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               in_func_i,
  input  logic [lldwa_pkg::SRC_ID_W-1:0]     in_source_id_i,
  input  logic [lldwa_pkg::WORKER_ID_W-1:0]  in_finishing_worker_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lldwa_pkg::WORKER_ID_W-1:0]  out_chosen_worker_o,
  output logic                               out_dispatched_o,
  output logic                               out_finish_done_o
);
  import lldwa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lldwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lldwa_dp #(
    .NUM_WORKERS (NUM_WORKERS),
    .NUM_SOURCES (NUM_SOURCES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_func_i             (in_func_i),
    .in_source_id_i        (in_source_id_i),
    .in_finishing_worker_i (in_finishing_worker_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .out_chosen_worker_o   (out_chosen_worker_o),
    .out_dispatched_o      (out_dispatched_o),
    .out_finish_done_o     (out_finish_done_o)
  );

endmodule

`default_nettype wire

### hw/rtl/lldwa_chk.sv
// ----------------------------------------------------------------------------
// lldwa_chk
// Port-level checks for the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lldwa_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [lldwa_pkg::WORKER_ID_W-1:0]  out_chosen_worker_o,
  input logic                               out_dispatched_o,
  input logic                               out_finish_done_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_chosen_worker_o)
      && $stable(out_dispatched_o) && $stable(out_finish_done_o))
    else $error("result changed while stalled");

  // every result is exactly one of dispatch or finish
  a_out_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_dispatched_o != out_finish_done_o))
    else $error("result kind flags inconsistent");

  // one item at a time: taking an item closes the input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // an item taken while no result is held cannot show its result at once
  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind least_loaded_dispatch_with_affinity_unit lldwa_chk u_lldwa_chk (.*);

`default_nettype wire

### tb/lldwa_dispatch_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lldwa_dispatch_checker
// Watches the config port and both item channels of the dispatcher. It keeps
// its own worker loads and source affinity records, predicts the result of
// every item taken, and compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module lldwa_dispatch_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lldwa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lldwa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                in_func_i,
  input  logic [lldwa_pkg::SRC_ID_W-1:0]      in_source_id_i,
  input  logic [lldwa_pkg::WORKER_ID_W-1:0]   in_finishing_worker_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [lldwa_pkg::WORKER_ID_W-1:0]   out_chosen_worker_i,
  input  logic                                out_dispatched_i,
  input  logic                                out_finish_done_i,
  output int                                  mismatch_count_o,
  output int                                  routes_pending_o
);
  import lldwa_pkg::*;

  localparam int NW = DEF_NUM_WORKERS;
  localparam int NS = DEF_NUM_SOURCES;
  localparam int CW = DEF_COUNT_WIDTH;

  typedef struct packed {
    logic [WORKER_ID_W-1:0] worker;
    logic                   dispatched;
    logic                   finish_done;
  } route_t;

  logic [CW-1:0]          load_q    [NW];
  logic                   src_busy  [NS];
  logic [CW-1:0]          src_cnt   [NS];
  logic [WORKER_ID_W-1:0] src_owner [NS];
  logic                   aff_on;
  logic [WIU_W-1:0]       wiu;

  route_t expected_routes [$];

  function automatic logic [CW-1:0] count_up(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + 1'b1;
  endfunction

  // out-of-range worker counts clamp to 1..NW; lowest index wins a tie
  function automatic logic [WORKER_ID_W-1:0] least_loaded_worker();
    int n;
    logic [WORKER_ID_W-1:0] best;
    n = (wiu == 0) ? 1 : ((wiu > NW) ? NW : int'(wiu));
    best = '0;
    for (int i = 1; i < n; i++) begin
      if (load_q[i] < load_q[best]) best = i[WORKER_ID_W-1:0];
    end
    return best;
  endfunction

  function automatic route_t route_item(input logic func,
                                        input logic [SRC_ID_W-1:0] src,
                                        input logic [WORKER_ID_W-1:0] fw);
    route_t res;
    logic [WORKER_ID_W-1:0] w;
    if (func == FUNC_SUBMIT) begin
      if (src_busy[src] && aff_on) begin
        // affinity hit: stays on the recorded worker even if beyond wiu
        src_cnt[src] = count_up(src_cnt[src]);
        w = src_owner[src];
      end else begin
        w = least_loaded_worker();
        src_busy[src]  = 1'b1;
        src_cnt[src]   = CW'(1);
        src_owner[src] = w;
      end
      load_q[w] = count_up(load_q[w]);
      res = '{worker: w, dispatched: 1'b1, finish_done: 1'b0};
    end else begin
      if (load_q[fw] != 0) load_q[fw] = load_q[fw] - 1'b1;
      if (src_busy[src]) begin
        if (src_cnt[src] <= 1) begin
          src_cnt[src]  = '0;
          src_busy[src] = 1'b0;
        end else begin
          src_cnt[src] = src_cnt[src] - 1'b1;
        end
      end
      res = '{worker: fw, dispatched: 1'b0, finish_done: 1'b1};
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_t got;
    route_t want;
    route_t pred;
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) load_q[i] = '0;
      for (int i = 0; i < NS; i++) begin
        src_busy[i] = 1'b0;
        src_cnt[i]  = '0;
      end
      aff_on = AFFINITY_RESET;
      wiu    = WIU_RESET;
      expected_routes.delete();
      mismatch_count_o = 0;
      routes_pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_AFFINITY_ENABLE) aff_on = cfg_data_i[0];
        else if (cfg_idx_i == REG_WORKERS_IN_USE) wiu = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        got = '{worker: out_chosen_worker_i, dispatched: out_dispatched_i,
                finish_done: out_finish_done_i};
        if (expected_routes.size() == 0) begin
          $display("%0t: unexpected result item: worker %0d dispatched %0b done %0b",
                   $time, got.worker, got.dispatched, got.finish_done);
          mismatch_count_o++;
        end else begin
          want = expected_routes.pop_front();
          if (got.worker !== want.worker) begin
            $display("%0t: chosen_worker expected %0d, got %0d",
                     $time, want.worker, got.worker);
            mismatch_count_o++;
          end
          if (got.dispatched !== want.dispatched) begin
            $display("%0t: dispatched expected %0b, got %0b",
                     $time, want.dispatched, got.dispatched);
            mismatch_count_o++;
          end
          if (got.finish_done !== want.finish_done) begin
            $display("%0t: finish_done expected %0b, got %0b",
                     $time, want.finish_done, got.finish_done);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pred = route_item(in_func_i, in_source_id_i, in_finishing_worker_i);
        expected_routes.insert(expected_routes.size(), pred);
      end
      routes_pending_o = expected_routes.size();
    end
  end

endmodule

### tb/least_loaded_dispatch_with_affinity_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_loaded_dispatch_with_affinity_unit_tb
// Drives submit and finish items into the dispatcher with random gaps and
// result back-pressure, switches affinity and worker count between phases,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module least_loaded_dispatch_with_affinity_unit_tb;
  import lldwa_pkg::*;

  localparam int RUN_LIMIT_NS    = 8_000_000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_PHASE      = 1;
  localparam int QUIET_PHASE     = 3;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 16;
  // per-phase settings, phase 0 in the low bits
  localparam logic [PHASES-1:0]   PHASE_AFF = 8'b1010_1101;
  localparam logic [4*PHASES-1:0] PHASE_WIU =
    {4'd2, 4'd8, 4'd5, 4'd0, 4'd15, 4'd1, 4'd3, 4'd8};

  logic                   clk_i                 = 1'b0;
  logic                   rst_ni                = 1'b0;
  logic                   cfg_we_i              = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i             = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i            = '0;
  logic                   in_valid_i            = 1'b0;
  logic                   in_func_i             = FUNC_SUBMIT;
  logic [SRC_ID_W-1:0]    in_source_id_i        = '0;
  logic [WORKER_ID_W-1:0] in_finishing_worker_i = '0;
  logic                   out_ready_i           = 1'b0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [WORKER_ID_W-1:0] out_chosen_worker_o;
  logic                   out_dispatched_o;
  logic                   out_finish_done_o;

  int   mismatch_count;
  int   routes_pending;
  logic quiet         = 1'b0;
  logic long_hold_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  least_loaded_dispatch_with_affinity_unit u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .in_func_i             (in_func_i),
    .in_source_id_i        (in_source_id_i),
    .in_finishing_worker_i (in_finishing_worker_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_chosen_worker_o   (out_chosen_worker_o),
    .out_dispatched_o      (out_dispatched_o),
    .out_finish_done_o     (out_finish_done_o)
  );

  lldwa_dispatch_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_i            (in_ready_o),
    .in_func_i             (in_func_i),
    .in_source_id_i        (in_source_id_i),
    .in_finishing_worker_i (in_finishing_worker_i),
    .out_valid_i           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_chosen_worker_i   (out_chosen_worker_o),
    .out_dispatched_i      (out_dispatched_o),
    .out_finish_done_i     (out_finish_done_o),
    .mismatch_count_o      (mismatch_count),
    .routes_pending_o      (routes_pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge; returns at a falling edge with valid possibly high
  task automatic send_item(input logic func, input logic [SRC_ID_W-1:0] src,
                           input logic [WORKER_ID_W-1:0] fw);
    int gap;
    in_valid_i            <= 1'b1;
    in_func_i             <= func;
    in_source_id_i        <= src;
    in_finishing_worker_i <= fw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // mostly a small pool of sources so affinity records get hit and cleared
  task automatic send_random(input int pool_base);
    logic [31:0]         r;
    logic [SRC_ID_W-1:0] src;
    logic                func;
    r = $urandom;
    if (r[1:0] != 2'b00) src = pool_base[SRC_ID_W-1:0] + {3'b000, r[4:2]};
    else src = r[10:5];
    func = ($urandom_range(0, 99) < 55) ? FUNC_SUBMIT : FUNC_FINISH;
    send_item(func, src, r[13:11]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (routes_pending != 0) @(negedge clk_i);
  endtask

  task automatic set_config(input logic aff, input logic [WIU_W-1:0] wiu);
    logic [31:0] r;
    drain();
    r = $urandom;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_AFFINITY_ENABLE;
    cfg_data_i <= {r[2:0], aff};
    @(negedge clk_i);
    cfg_idx_i  <= REG_WORKERS_IN_USE;
    cfg_data_i <= wiu;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_side
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat (1 + idle_len()) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int pool_base;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: affinity on, all eight workers
    send_item(FUNC_SUBMIT, 6'd0, 3'd7);
    send_item(FUNC_SUBMIT, 6'd0, 3'd0);
    send_item(FUNC_SUBMIT, 6'd63, 3'd7);
    send_item(FUNC_FINISH, 6'd63, 3'd1);
    send_item(FUNC_FINISH, 6'd63, 3'd1);   // load already zero, source idle
    send_item(FUNC_FINISH, 6'd0, 3'd7);
    for (int s = 32; s < 40; s++) send_item(FUNC_SUBMIT, s[5:0], 3'd0);
    // some recorded workers now lie beyond the two in use
    set_config(1'b1, 4'd2);
    send_item(FUNC_SUBMIT, 6'd39, 3'd5);
    send_item(FUNC_SUBMIT, 6'd38, 3'd2);
    set_config(1'b1, 4'd0);                // acts as one worker
    send_item(FUNC_SUBMIT, 6'd17, 3'd3);
    set_config(1'b1, 4'd15);               // acts as all workers
    send_item(FUNC_SUBMIT, 6'd18, 3'd4);
    // affinity off: an active source gets re-picked and its record rewritten
    set_config(1'b0, 4'd8);
    send_item(FUNC_SUBMIT, 6'd0, 3'd6);
    send_item(FUNC_SUBMIT, 6'd0, 3'd1);
    send_item(FUNC_FINISH, 6'd42, 3'd4);
    send_item(FUNC_FINISH, 6'd0, 3'd0);
    send_item(FUNC_FINISH, 6'd32, 3'd5);

    for (int p = 0; p < PHASES; p++) begin
      set_config(PHASE_AFF[p], PHASE_WIU[p*4 +: 4]);
      quiet = (p == QUIET_PHASE);
      pool_base = $urandom_range(0, 56);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == HOLD_PHASE && k == 40) long_hold_req = 1'b1;
        send_random(pool_base);
      end
    end
    quiet = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && routes_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
